[hw/rtl/csft_pkg.sv]
`timescale 1ns / 1ps

package csft_pkg;

  localparam int STOP_W    = 12;
  localparam int SLOT_W    = 4;
  localparam int TIME_W    = 18;
  localparam int XFER_W    = 13;
  localparam int TRIP_W    = 16;
  localparam int DUR_W     = 16;
  localparam int CNT_W     = 5;
  localparam int PATH_AW   = STOP_W + SLOT_W;

  localparam int NUM_STOPS     = 1 << STOP_W;
  localparam int MAX_FOOTPATHS = 1 << SLOT_W;
  localparam int PATH_DEPTH    = 1 << PATH_AW;

  localparam logic [TIME_W-1:0] TIME_INF      = '1;
  localparam logic [XFER_W-1:0] STOP_NONE     = XFER_W'(NUM_STOPS);
  localparam logic [TIME_W-1:0] HORIZON_RESET = TIME_W'(14400);
  localparam logic [STOP_W-1:0] STOP_LAST     = '1;
  localparam logic [CNT_W-1:0]  CNT_MAX       = CNT_W'(MAX_FOOTPATHS);

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_CONN  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  typedef struct packed {
    logic [1:0]        operation;
    logic [STOP_W-1:0] src_stop;
    logic [STOP_W-1:0] to_stop;
    logic [TIME_W-1:0] departure;
    logic [TIME_W-1:0] arrival;
    logic [TRIP_W-1:0] trip;
    logic              first_of_scan;
    logic [SLOT_W-1:0] footpath_slot;
    logic [DUR_W-1:0]  footpath_duration;
  } in_t;

  typedef struct packed {
    logic [TIME_W-1:0] earliest_arrival;
    logic [XFER_W-1:0] first_transfer_stop;
    logic              improved;
  } out_t;

  typedef struct packed {
    logic [TIME_W-1:0] arr;
    logic [XFER_W-1:0] xfer;
  } label_t;

  typedef struct packed {
    logic [STOP_W-1:0] dest;
    logic [DUR_W-1:0]  dur;
  } path_t;

endpackage

[hw/rtl/connection_scan_first_transfer_unit.sv]
`timescale 1ns / 1ps
// Earliest-arrival connection scan with first-transfer tracking.
// Input channel in_valid/in_ready/in_data carries one transaction: a footpath
// load, a connection or a stop query. Every transaction returns one result on
// out_valid/out_ready/out_data. cfg_valid/cfg_ready/cfg_data writes the scan
// horizon; write it only while the unit is idle.
// Footpaths, per-stop footpath counts and per-stop labels live in simple
// dual-port memories with a registered read; one label read and one label write
// per cycle set the pace. A load writes its footpath and count when accepted, a
// query reads one label, and a connection reads both labels and, on improvement,
// relaxes each target footpath in turn; a scan start adds a sweep of all labels.
// The unit takes one transaction at a time; in_ready rises again once the
// result sits in the output register, and the next one can be accepted while
// the receiver stalls. A result held by a stalled receiver blocks only the
// hand-off of the following result. After reset the unit sweeps all 4096 stops
// (labels to unreached, footpath counts to zero) with in_ready low; the horizon
// resets to 14400.
module connection_scan_first_transfer_unit
  import csft_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_t              out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [TIME_W-1:0] cfg_data
);

  localparam logic [3:0] S_SWEEP = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CFROM = 4'd2;
  localparam logic [3:0] S_CTO   = 4'd3;
  localparam logic [3:0] S_CDEC  = 4'd4;
  localparam logic [3:0] S_PRD   = 4'd5;
  localparam logic [3:0] S_PLBL  = 4'd6;
  localparam logic [3:0] S_PUPD  = 4'd7;
  localparam logic [3:0] S_QRD   = 4'd8;
  localparam logic [3:0] S_QRES  = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  label_t lbl_mem [NUM_STOPS];
  logic [CNT_W-1:0] cnt_mem [NUM_STOPS];
  path_t path_mem [PATH_DEPTH];

  logic [3:0]        state_r, state_nxt;
  logic [STOP_W-1:0] clr_idx_r, clr_idx_nxt;
  logic              sweep_all_r, sweep_all_nxt;
  logic [TIME_W-1:0] horizon_r, horizon_nxt;
  logic [TRIP_W-1:0] start_trip_r, start_trip_nxt;
  logic [TIME_W-1:0] start_dep_r, start_dep_nxt;
  logic              out_valid_r, out_valid_nxt;

  in_t               item_r, item_nxt;
  logic              use_r, use_nxt;
  logic [XFER_W-1:0] from_xfer_r, from_xfer_nxt;
  logic [XFER_W-1:0] to_xfer_r, to_xfer_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [CNT_W-1:0]  j_r, j_nxt;
  logic [STOP_W-1:0] dest_r, dest_nxt;
  logic [TIME_W-1:0] walk_r, walk_nxt;
  out_t              res_r, res_nxt;
  out_t              out_data_r, out_data_nxt;

  label_t            lbl_q;
  logic [CNT_W-1:0]  cnt_q;
  path_t             path_q;

  logic              lbl_we;
  logic [STOP_W-1:0] lbl_waddr;
  label_t            lbl_wdata;
  logic [STOP_W-1:0] lbl_raddr;
  logic              cnt_we;
  logic [STOP_W-1:0] cnt_waddr;
  logic [CNT_W-1:0]  cnt_wdata;
  logic              path_we;

  logic [TIME_W:0]   window_end;
  logic [TIME_W:0]   walk_sum;
  logic [XFER_W-1:0] new_xfer;
  logic [CNT_W-1:0]  cnt_clip;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign window_end = {1'b0, start_dep_r} + {1'b0, horizon_r};
  assign walk_sum   = {1'b0, item_r.arrival} + {{(TIME_W + 1 - DUR_W){1'b0}}, path_q.dur};
  assign new_xfer   = (item_r.trip == start_trip_r) ? {1'b0, item_r.to_stop} : from_xfer_r;
  assign cnt_clip   = (cnt_q > CNT_MAX) ? CNT_MAX : cnt_q;

  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    sweep_all_nxt  = sweep_all_r;
    horizon_nxt    = cfg_valid ? cfg_data : horizon_r;
    start_trip_nxt = start_trip_r;
    start_dep_nxt  = start_dep_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    item_nxt       = item_r;
    use_nxt        = use_r;
    from_xfer_nxt  = from_xfer_r;
    to_xfer_nxt    = to_xfer_r;
    n_nxt          = n_r;
    j_nxt          = j_r;
    dest_nxt       = dest_r;
    walk_nxt       = walk_r;
    res_nxt        = res_r;
    out_data_nxt   = out_data_r;
    lbl_we         = 1'b0;
    lbl_waddr      = clr_idx_r;
    lbl_wdata      = {TIME_INF, STOP_NONE};
    lbl_raddr      = item_r.src_stop;
    cnt_we         = 1'b0;
    cnt_waddr      = clr_idx_r;
    cnt_wdata      = '0;
    path_we        = 1'b0;
    case (state_r)
      S_SWEEP: begin
        lbl_we      = 1'b1;
        cnt_we      = sweep_all_r;
        clr_idx_nxt = clr_idx_r + STOP_W'(1);
        if (clr_idx_r == STOP_LAST) begin
          state_nxt     = sweep_all_r ? S_IDLE : S_CFROM;
          sweep_all_nxt = 1'b0;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          res_nxt  = '0;
          case (in_data.operation)
            OP_LOAD: begin
              path_we   = 1'b1;
              cnt_we    = 1'b1;
              cnt_waddr = in_data.src_stop;
              cnt_wdata = {1'b0, in_data.footpath_slot} + CNT_W'(1);
              state_nxt = S_DONE;
            end
            OP_CONN: begin
              if (in_data.first_of_scan) begin
                start_trip_nxt = in_data.trip;
                start_dep_nxt  = in_data.departure;
                state_nxt      = S_SWEEP;
              end else begin
                state_nxt = S_CFROM;
              end
            end
            OP_QUERY: state_nxt = S_QRD;
            default:  state_nxt = S_DONE;
          endcase
        end
      end
      S_CFROM: begin
        lbl_raddr = item_r.src_stop;
        state_nxt = S_CTO;
      end
      S_CTO: begin
        lbl_raddr     = item_r.to_stop;
        use_nxt       = item_r.first_of_scan ||
                        (({1'b0, item_r.departure} < window_end) &&
                         (lbl_q.arr != TIME_INF) && (lbl_q.arr <= item_r.departure));
        from_xfer_nxt = lbl_q.xfer;
        state_nxt     = S_CDEC;
      end
      S_CDEC: begin
        if (use_r && (item_r.arrival < lbl_q.arr)) begin
          res_nxt.improved = 1'b1;
          lbl_we      = 1'b1;
          lbl_waddr   = item_r.to_stop;
          lbl_wdata   = {lbl_q.arr, new_xfer};
          to_xfer_nxt = new_xfer;
          n_nxt       = cnt_clip;
          j_nxt       = '0;
          state_nxt   = (cnt_clip == '0) ? S_DONE : S_PRD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_PRD: state_nxt = S_PLBL;
      S_PLBL: begin
        lbl_raddr = path_q.dest;
        dest_nxt  = path_q.dest;
        walk_nxt  = walk_sum[TIME_W] ? TIME_INF : walk_sum[TIME_W-1:0];
        state_nxt = S_PUPD;
      end
      S_PUPD: begin
        if (walk_r < lbl_q.arr) begin
          lbl_we    = 1'b1;
          lbl_waddr = dest_r;
          lbl_wdata = {walk_r, to_xfer_r};
        end
        j_nxt     = j_r + CNT_W'(1);
        state_nxt = ((j_r + CNT_W'(1)) == n_r) ? S_DONE : S_PRD;
      end
      S_QRD: begin
        lbl_raddr = item_r.to_stop;
        state_nxt = S_QRES;
      end
      S_QRES: begin
        res_nxt.earliest_arrival    = lbl_q.arr;
        res_nxt.first_transfer_stop = lbl_q.xfer;
        state_nxt                   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_SWEEP;
      clr_idx_r    <= '0;
      sweep_all_r  <= 1'b1;
      horizon_r    <= HORIZON_RESET;
      start_trip_r <= '0;
      start_dep_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_idx_r    <= clr_idx_nxt;
      sweep_all_r  <= sweep_all_nxt;
      horizon_r    <= horizon_nxt;
      start_trip_r <= start_trip_nxt;
      start_dep_r  <= start_dep_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    use_r       <= use_nxt;
    from_xfer_r <= from_xfer_nxt;
    to_xfer_r   <= to_xfer_nxt;
    n_r         <= n_nxt;
    j_r         <= j_nxt;
    dest_r      <= dest_nxt;
    walk_r      <= walk_nxt;
    res_r       <= res_nxt;
    out_data_r  <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (lbl_we) begin
      lbl_mem[lbl_waddr] <= lbl_wdata;
    end
    lbl_q <= lbl_mem[lbl_raddr];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_q <= cnt_mem[item_r.to_stop];
  end

  always_ff @(posedge clk) begin
    if (path_we) begin
      path_mem[{in_data.src_stop, in_data.footpath_slot}] <=
        {in_data.to_stop, in_data.footpath_duration};
    end
    path_q <= path_mem[{item_r.to_stop, j_r[SLOT_W-1:0]}];
  end

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a transaction is in progress");

  a_relax_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PUPD |-> j_r < n_r && n_r <= CNT_MAX)
    else $error("footpath index beyond stop's footpath count");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !lbl_we)
    else $error("label write while idle");

  a_unused_not_improved: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CDEC && !use_r |=> !res_r.improved)
    else $error("improvement flagged for an unused connection");
`endif

endmodule

[tb/tb_connection_scan_first_transfer_unit.sv]
`timescale 1ns / 1ps

module tb_connection_scan_first_transfer_unit;
  import csft_pkg::*;

  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam int         TIME_LAST  = 262142;
  localparam int         POOL_N     = 20;
  localparam int         PHASES     = 6;
  localparam int         PHASE_LEN  = 125;
  localparam int         HOLD_AT    = 300;
  localparam int         LONG_HOLD  = 500;
  localparam int         SETTLE     = 8;
  localparam int         FINAL_WAIT = 64;
  localparam int         WDOG_LIMIT = 20000;

  class transfer_scoreboard;
    logic [TIME_W-1:0] best_time  [NUM_STOPS];
    logic [XFER_W-1:0] first_xfer [NUM_STOPS];
    logic [CNT_W-1:0]  walk_cnt   [NUM_STOPS];
    logic [STOP_W-1:0] walk_dest  [PATH_DEPTH];
    logic [DUR_W-1:0]  walk_dur   [PATH_DEPTH];
    logic [TRIP_W-1:0] origin_trip;
    logic [TIME_W-1:0] origin_dep;
    logic [TIME_W-1:0] window;
    out_t              expected_answers [$];
    int                mismatches;
    int                results_seen;

    function new();
      for (int s = 0; s < NUM_STOPS; s++) walk_cnt[s] = '0;
      for (int k = 0; k < PATH_DEPTH; k++) begin
        walk_dest[k] = '0;
        walk_dur[k]  = '0;
      end
      reset_labels();
      origin_trip  = '0;
      origin_dep   = '0;
      window       = HORIZON_RESET;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void reset_labels();
      for (int s = 0; s < NUM_STOPS; s++) begin
        best_time[s]  = TIME_INF;
        first_xfer[s] = STOP_NONE;
      end
    endfunction

    function void set_window(logic [TIME_W-1:0] h);
      window = h;
    endfunction

    function out_t advance_scan(in_t x);
      out_t              r;
      logic              ride;
      int                n;
      int                k;
      logic [STOP_W-1:0] d;
      logic [TIME_W:0]   t;
      r = '0;
      case (x.operation)
        OP_LOAD: begin
          k = int'(x.src_stop) * MAX_FOOTPATHS + int'(x.footpath_slot);
          walk_dest[k] = x.to_stop;
          walk_dur[k]  = x.footpath_duration;
          walk_cnt[x.src_stop] = {1'b0, x.footpath_slot} + 5'd1;
        end
        OP_CONN: begin
          if (x.first_of_scan) begin
            reset_labels();
            origin_trip = x.trip;
            origin_dep  = x.departure;
            ride = 1'b1;
          end else begin
            ride = ({1'b0, x.departure} < {1'b0, origin_dep} + {1'b0, window}) &&
                   best_time[x.src_stop] != TIME_INF &&
                   best_time[x.src_stop] <= x.departure;
          end
          if (ride && x.arrival < best_time[x.to_stop]) begin
            r.improved = 1'b1;
            if (x.trip == origin_trip) first_xfer[x.to_stop] = {1'b0, x.to_stop};
            else first_xfer[x.to_stop] = first_xfer[x.src_stop];
            n = int'(walk_cnt[x.to_stop]);
            for (int j = 0; j < n; j++) begin
              k = int'(x.to_stop) * MAX_FOOTPATHS + j;
              d = walk_dest[k];
              t = {1'b0, x.arrival} + {3'b000, walk_dur[k]};
              if (t > {1'b0, TIME_INF}) t = {1'b0, TIME_INF};
              if (t[TIME_W-1:0] < best_time[d]) begin
                best_time[d]  = t[TIME_W-1:0];
                first_xfer[d] = first_xfer[x.to_stop];
              end
            end
          end
        end
        OP_QUERY: begin
          r.earliest_arrival    = best_time[x.to_stop];
          r.first_transfer_stop = first_xfer[x.to_stop];
        end
        default: begin
        end
      endcase
      return r;
    endfunction

    function void note_input(in_t x);
      expected_answers.insert(expected_answers.size(), advance_scan(x));
    endfunction

    task report(string msg);
      $display("%0t ns: mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(out_t got);
      out_t want;
      results_seen++;
      if (expected_answers.size() == 0) begin
        report($sformatf("unexpected transaction %h", got));
        return;
      end
      want = expected_answers.pop_front();
      if (got.earliest_arrival !== want.earliest_arrival)
        report($sformatf("earliest_arrival %0d, want %0d",
                         got.earliest_arrival, want.earliest_arrival));
      if (got.first_transfer_stop !== want.first_transfer_stop)
        report($sformatf("first_transfer_stop %0d, want %0d",
                         got.first_transfer_stop, want.first_transfer_stop));
      if (got.improved !== want.improved)
        report($sformatf("improved %0b, want %0b", got.improved, want.improved));
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_t               in_data;
  logic              out_valid;
  logic              out_ready;
  out_t              out_data;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [TIME_W-1:0] cfg_data;

  transfer_scoreboard sb;
  transfer_scoreboard plan;
  logic [STOP_W-1:0]  pool [POOL_N];
  int                 items_sent;
  int                 calm_items;
  bit                 no_idle;
  bit                 hold_request;

  connection_scan_first_transfer_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (in_valid && in_ready) sb.note_input(in_data);
    if (out_valid && out_ready) sb.check_result(out_data);
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("tb_connection_scan_first_transfer_unit NOT OK");
    $finish;
  end

  initial begin
    int stall_left;
    int calm_left;
    stall_left = 0;
    calm_left  = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (no_idle || calm_left > 0) begin
        if (calm_left > 0) calm_left--;
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 59) == 0) begin
        calm_left = $urandom_range(40, 200);
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic in_t junk_item();
    in_t x;
    x.operation         = 2'($urandom());
    x.src_stop          = STOP_W'($urandom());
    x.to_stop           = STOP_W'($urandom());
    x.departure         = TIME_W'($urandom_range(0, TIME_LAST));
    x.arrival           = TIME_W'($urandom_range(0, TIME_LAST));
    x.trip              = TRIP_W'($urandom());
    x.first_of_scan     = 1'($urandom());
    x.footpath_slot     = SLOT_W'($urandom());
    x.footpath_duration = DUR_W'($urandom());
    return x;
  endfunction

  function automatic in_t mk(logic [1:0] op, int from, int to, int dep, int arr,
                             int trip, bit first, int slot, int dur);
    in_t x;
    x.operation         = op;
    x.src_stop          = STOP_W'(from);
    x.to_stop           = STOP_W'(to);
    x.departure         = TIME_W'(dep);
    x.arrival           = TIME_W'(arr);
    x.trip              = TRIP_W'(trip);
    x.first_of_scan     = first;
    x.footpath_slot     = SLOT_W'(slot);
    x.footpath_duration = DUR_W'(dur);
    return x;
  endfunction

  function automatic logic [STOP_W-1:0] pick_stop();
    return pool[$urandom_range(0, POOL_N - 1)];
  endfunction

  function automatic logic [STOP_W-1:0] reached_stop();
    logic [STOP_W-1:0] s;
    for (int i = 0; i < 8; i++) begin
      s = pick_stop();
      if (plan.best_time[s] != TIME_INF) return s;
    end
    return pick_stop();
  endfunction

  function automatic int clamp_time(int t);
    return (t > TIME_LAST) ? TIME_LAST : t;
  endfunction

  task automatic pause_input(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic issue(input in_t item);
    void'(plan.advance_scan(item));
    if (!no_idle) begin
      if (calm_items > 0) calm_items--;
      else if ($urandom_range(0, 29) == 0) calm_items = $urandom_range(10, 40);
      else if ($urandom_range(0, 3) == 0) pause_input($urandom_range(1, 6));
    end
    if (items_sent == HOLD_AT) hold_request = 1'b1;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_ready !== 1'b1);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.results_seen < items_sent) @(posedge clk);
  endtask

  task automatic write_window(input logic [TIME_W-1:0] h);
    wait_idle();
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= h;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    sb.set_window(h);
    plan.set_window(h);
  endtask

  task automatic load_list(input logic [STOP_W-1:0] stop, input int len);
    in_t x;
    for (int slot = 0; slot < len; slot++) begin
      x = junk_item();
      x.operation     = OP_LOAD;
      x.src_stop      = stop;
      x.footpath_slot = SLOT_W'(slot);
      x.to_stop       = (slot == 0 && $urandom_range(0, 3) != 0) ? stop : pick_stop();
      if ($urandom_range(0, 9) != 0) x.footpath_duration = DUR_W'($urandom_range(0, 120));
      issue(x);
    end
  endtask

  task automatic run_scan(input int steps);
    in_t               x;
    int                now;
    int                reach;
    int                base;
    int                dep;
    int                pick;
    int                top;
    logic [TRIP_W-1:0] line_trip;
    logic [STOP_W-1:0] s;
    if ($urandom_range(0, 1) == 1) begin
      repeat ($urandom_range(1, 3))
        load_list(pick_stop(), ($urandom_range(0, 4) == 0) ? $urandom_range(5, 16)
                                                           : $urandom_range(1, 4));
    end
    x = junk_item();
    x.operation     = OP_CONN;
    x.first_of_scan = 1'b1;
    x.src_stop      = pick_stop();
    x.to_stop       = pick_stop();
    dep = ($urandom_range(0, 7) == 0) ? $urandom_range(0, TIME_LAST)
                                      : $urandom_range(0, 200000);
    x.departure = TIME_W'(dep);
    x.arrival   = TIME_W'(clamp_time(dep + $urandom_range(0, 300)));
    now       = dep;
    line_trip = TRIP_W'($urandom());
    issue(x);
    repeat (steps) begin
      pick = $urandom_range(0, 99);
      x = junk_item();
      if (pick < 55) begin
        x.operation     = OP_CONN;
        x.first_of_scan = 1'b0;
        x.src_stop      = reached_stop();
        x.to_stop       = pick_stop();
        reach = int'(plan.best_time[x.src_stop]);
        base  = (reach != int'(TIME_INF) && reach > now) ? reach : now;
        case ($urandom_range(0, 11))
          0: dep = (reach != int'(TIME_INF) && reach > 0) ? reach - 1 : base;
          1: dep = base + $urandom_range(0, 20000);
          default: dep = base + $urandom_range(0, 40);
        endcase
        dep = clamp_time(dep);
        x.departure = TIME_W'(dep);
        x.arrival   = TIME_W'(clamp_time(dep + $urandom_range(0, 400)));
        case ($urandom_range(0, 2))
          0: x.trip = plan.origin_trip;
          1: x.trip = line_trip;
          default: x.trip = TRIP_W'($urandom());
        endcase
        if (dep > now) now = dep;
      end else if (pick < 80) begin
        x.operation = OP_QUERY;
        x.to_stop   = pick_stop();
      end else if (pick < 88) begin
        s   = pick_stop();
        top = int'(plan.walk_cnt[s]);
        if (top > MAX_FOOTPATHS - 1) top = MAX_FOOTPATHS - 1;
        x.operation     = OP_LOAD;
        x.src_stop      = s;
        x.to_stop       = pick_stop();
        x.footpath_slot = SLOT_W'($urandom_range(0, top));
      end else if (pick < 93) begin
        x.operation = OP_QUERY;
      end else if (pick < 97) begin
        x.operation = OP_CONN;
      end else begin
        x.operation = OP_UNUSED;
      end
      issue(x);
    end
  endtask

  initial begin
    logic [TIME_W-1:0] windows [PHASES];
    int                target;
    sb   = new();
    plan = new();
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_data    <= '0;
    cfg_valid  <= 1'b0;
    cfg_data   <= '0;
    items_sent   = 0;
    calm_items   = 0;
    no_idle      = 1'b0;
    hold_request = 1'b0;
    pool[0] = '0;
    pool[1] = STOP_LAST;
    pool[2] = STOP_W'(5);
    for (int i = 3; i < POOL_N; i++) pool[i] = STOP_W'($urandom());
    windows[0] = HORIZON_RESET;
    windows[1] = '0;
    windows[2] = TIME_INF;
    windows[3] = TIME_W'($urandom_range(50, 2000));
    windows[4] = TIME_W'(1);
    windows[5] = HORIZON_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    issue(mk(OP_QUERY, 0, 0, 0, 0, 0, 1'b0, 0, 0));
    issue(mk(OP_QUERY, 0, 4095, 0, 0, 0, 1'b0, 0, 0));
    issue(mk(OP_UNUSED, 4095, 4095, TIME_LAST, TIME_LAST, 65535, 1'b1, 15, 65535));
    issue(mk(OP_LOAD, 5, 5, 0, 0, 0, 1'b0, 0, 0));
    issue(mk(OP_LOAD, 5, 4095, 0, 0, 0, 1'b0, 1, 65535));
    issue(mk(OP_LOAD, 4095, 4095, 0, 0, 0, 1'b0, 0, 0));
    issue(mk(OP_LOAD, 4095, 0, 0, 0, 0, 1'b0, 1, 10));
    issue(mk(OP_CONN, 0, 5, 0, 1, 0, 1'b0, 0, 0));
    issue(mk(OP_CONN, 0, 5, 100, 200, 65535, 1'b1, 0, 0));
    issue(mk(OP_QUERY, 0, 5, 0, 0, 0, 1'b0, 0, 0));
    issue(mk(OP_CONN, 5, 4095, 200, 300, 4660, 1'b0, 0, 0));
    issue(mk(OP_QUERY, 0, 4095, 0, 0, 0, 1'b0, 0, 0));
    issue(mk(OP_QUERY, 0, 0, 0, 0, 0, 1'b0, 0, 0));
    issue(mk(OP_CONN, 5, 4095, 199, 250, 4660, 1'b0, 0, 0));
    issue(mk(OP_CONN, 0, 5, 14500, 150, 65535, 1'b0, 0, 0));
    issue(mk(OP_CONN, 0, 5, 14499, 150, 65535, 1'b0, 0, 0));
    issue(mk(OP_QUERY, 0, 5, 0, 0, 0, 1'b0, 0, 0));
    issue(mk(OP_CONN, 0, 7, 14000, 400, 77, 1'b0, 0, 0));
    issue(mk(OP_QUERY, 0, 7, 0, 0, 0, 1'b0, 0, 0));
    issue(mk(OP_CONN, 1, 5, TIME_LAST, TIME_LAST, 0, 1'b1, 0, 0));
    issue(mk(OP_QUERY, 0, 4095, 0, 0, 0, 1'b0, 0, 0));
    issue(mk(OP_QUERY, 0, 5, 0, 0, 0, 1'b0, 0, 0));
    issue(mk(OP_LOAD, 5, 9, 0, 0, 0, 1'b0, 0, 3));

    target = items_sent;
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) write_window(windows[p]);
      if (p == PHASES - 1) no_idle = 1'b1;
      target += PHASE_LEN;
      while (items_sent < target) run_scan($urandom_range(5, 20));
    end

    wait_idle();
    repeat (FINAL_WAIT) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_answers.size() == 0)
      $display("tb_connection_scan_first_transfer_unit OK");
    else
      $display("tb_connection_scan_first_transfer_unit NOT OK");
    $finish;
  end

endmodule
